// File: rtl/assert_macros.svh
// Assertion macros used by the packet builder RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on the rising clock edge, off in reset
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("packet builder check failed");

// Next-cycle implication, sampled on the rising clock edge, off in reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("packet builder check failed");

`else

`define ASSERT_SAME(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: rtl/rmapcpb_pkg.sv
// Shared types and constants for the RMAP command packet builder.
// No dependencies.
package rmapcpb_pkg;

  // Fixed header bytes
  localparam logic [7:0] PROTOCOL_ID   = 8'h01;
  localparam logic [7:0] EXT_ADDRESS   = 8'h00;
  localparam logic [7:0] WRITE_LEN_HI  = 8'h00;
  localparam logic [7:0] WRITE_LEN_MID = 8'h00;
  localparam logic [7:0] WRITE_LEN_LO  = 8'h04;

  // Command bit that selects a single-word write
  localparam int WRITE_BIT = 5;

  // Bytes covered by the header CRC and by the data CRC
  localparam int HDR_LEN  = 15;
  localparam int DATA_LEN = 4;

  // Reflected form of x^8+x^2+x+1
  localparam logic [7:0] CRC_POLY_REFL = 8'hE0;

  // Byte sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEADER,
    ST_HEADER_CRC,
    ST_DATA,
    ST_DATA_CRC
  } seq_state_t;

  // Control from the sequencer to the CRC unit
  typedef struct packed {
    logic clear;
    logic update;
  } crc_ctrl_t;

endpackage

// File: rtl/rmapcpb_crc8.sv
// Byte-wide RMAP CRC-8 accumulator, one packet byte folded in per cycle while update is set.
// Depends on rmapcpb_pkg for the polynomial and the control struct.
module rmapcpb_crc8 (
  input  logic                   clk,
  input  rmapcpb_pkg::crc_ctrl_t ctrl,
  input  logic [7:0]             din,
  output logic [7:0]             crc
);
  import rmapcpb_pkg::*;

  logic [7:0] crc_next;

  // Fold one byte in, least significant bit first
  always_comb begin
    logic [7:0] v;
    v = crc ^ din;
    for (int k = 0; k < 8; k++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CRC_POLY_REFL;
      end else begin
        v = v >> 1;
      end
    end
    crc_next = v;
  end

  // Clear at the start of each CRC span, advance on each covered byte
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      crc <= 8'h00;
    end else if (ctrl.update) begin
      crc <= crc_next;
    end
  end

endmodule

// File: rtl/rmap_command_packet_builder_core.sv
// RMAP command packet builder: one request in, its packet out a byte at a time.
// Depends on rmapcpb_pkg, rmapcpb_crc8 and assert_macros.svh.
//
// Input channel (in_valid/in_ready) carries one command request. The request
// is loaded into a byte-wide shift register and the output channel
// (out_valid/out_ready) then carries the packet: packet_byte with last_byte
// set on the final byte. A read command gives 16 bytes (15 header bytes and
// the header CRC); a write command gives 21 (header, header CRC, four data
// bytes least significant first, data CRC).
// The request transfer loads the shift register and enters the header state;
// the first byte then moves into the output register. With out_ready held
// high the packet goes out one byte per cycle, set by the shift register and
// the one-byte-per-cycle CRC unit. The next request is taken once the last
// byte sits in the output register.
// When the receiver stalls, the output register holds its byte and the
// shift register and CRC stop with it. Reset drops any packet in flight,
// empties the output register and leaves the block ready for a request.
module rmap_command_packet_builder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  command_byte,
  input  logic [7:0]  source_address,
  input  logic [7:0]  dest_address,
  input  logic [7:0]  dest_key,
  input  logic [15:0] transaction_id,
  input  logic [31:0] target_address,
  input  logic [23:0] read_length,
  input  logic [31:0] write_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  packet_byte,
  output logic        last_byte
);
  import rmapcpb_pkg::*;
  `include "assert_macros.svh"

  localparam int SREG_W = (HDR_LEN + DATA_LEN) * 8;
  localparam logic [3:0] HDR_LAST  = 4'(HDR_LEN - 1);
  localparam logic [3:0] DATA_LAST = 4'(DATA_LEN - 1);

  seq_state_t        state, state_next;
  logic [SREG_W-1:0] sreg, sreg_next;
  logic [3:0]        cnt, cnt_next;
  logic              is_write, is_write_next;
  logic              load_out;
  logic [7:0]        byte_next;
  logic              last_next;
  logic              advance;
  crc_ctrl_t         crc_ctrl;
  logic [7:0]        crc;
  logic [7:0]        head_byte;

  assign head_byte = sreg[SREG_W-1 -: 8];
  assign advance   = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);

  // Fold each header and data byte into the running CRC
  rmapcpb_crc8 u_crc (
    .clk  (clk),
    .ctrl (crc_ctrl),
    .din  (head_byte),
    .crc  (crc)
  );

  // Sequencer: load the request, then shift out one byte per free slot
  always_comb begin
    state_next    = state;
    sreg_next     = sreg;
    cnt_next      = cnt;
    is_write_next = is_write;
    load_out      = 1'b0;
    byte_next     = head_byte;
    last_next     = 1'b0;
    crc_ctrl      = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          is_write_next = command_byte[WRITE_BIT];
          if (command_byte[WRITE_BIT]) begin
            sreg_next = {dest_address, PROTOCOL_ID, command_byte, dest_key,
                         source_address, transaction_id, EXT_ADDRESS,
                         target_address, WRITE_LEN_HI, WRITE_LEN_MID,
                         WRITE_LEN_LO, write_word[7:0], write_word[15:8],
                         write_word[23:16], write_word[31:24]};
          end else begin
            sreg_next = {dest_address, PROTOCOL_ID, command_byte, dest_key,
                         source_address, transaction_id, EXT_ADDRESS,
                         target_address, read_length, 32'h0000_0000};
          end
          cnt_next       = '0;
          crc_ctrl.clear = 1'b1;
          state_next     = ST_HEADER;
        end
      end
      ST_HEADER: begin
        if (advance) begin
          load_out        = 1'b1;
          crc_ctrl.update = 1'b1;
          sreg_next       = {sreg[SREG_W-9:0], 8'h00};
          cnt_next        = cnt + 4'd1;
          if (cnt == HDR_LAST) begin
            cnt_next   = '0;
            state_next = ST_HEADER_CRC;
          end
        end
      end
      ST_HEADER_CRC: begin
        if (advance) begin
          load_out       = 1'b1;
          byte_next      = crc;
          crc_ctrl.clear = 1'b1;
          if (is_write) begin
            state_next = ST_DATA;
          end else begin
            last_next  = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_DATA: begin
        if (advance) begin
          load_out        = 1'b1;
          crc_ctrl.update = 1'b1;
          sreg_next       = {sreg[SREG_W-9:0], 8'h00};
          cnt_next        = cnt + 4'd1;
          if (cnt == DATA_LAST) begin
            cnt_next   = '0;
            state_next = ST_DATA_CRC;
          end
        end
      end
      ST_DATA_CRC: begin
        if (advance) begin
          load_out   = 1'b1;
          byte_next  = crc;
          last_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Shift register and command flavour
  always_ff @(posedge clk) begin
    sreg     <= sreg_next;
    is_write <= is_write_next;
  end

  // Output register: hold while stalled, drop valid once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      packet_byte <= byte_next;
      last_byte   <= last_next;
    end
  end

  // A pending last byte means the sequencer has finished or only just restarted
  `ASSERT_SAME(a_last_then_idle, clk, rst, out_valid && last_byte,
               state == ST_IDLE || (state == ST_HEADER && cnt == 4'd0))
  // Data phase only follows a write command
  `ASSERT_SAME(a_data_is_write, clk, rst,
               state == ST_DATA || state == ST_DATA_CRC, is_write)
  // A request transfer starts the header from its first byte
  `ASSERT_NEXT(a_start_header, clk, rst, in_valid && in_ready,
               state == ST_HEADER && cnt == 4'd0)
  // The CRC byte phases never carry a partial count
  `ASSERT_SAME(a_crc_cnt_zero, clk, rst,
               state == ST_HEADER_CRC || state == ST_DATA_CRC, cnt == 4'd0)

endmodule
